[rtl/rut_pkg.sv]
// ----------------------------------------------------------------------------
// rut_pkg
// Shared types, codes and helpers for the unacknowledged packet tracker.
// ----------------------------------------------------------------------------
package rut_pkg;

   // Default number of table entries.
   localparam int TABLE_DEPTH_DEF = 32;

   // An ack covers a sequence when the serial distance is below one half.
   localparam logic [31:0] SERIAL_HALF = 32'h8000_0000;

   // Largest value that a 6-bit count field can report.
   localparam logic [5:0] COUNT_MAX = 6'd63;

   // Item action codes.
   localparam logic ACT_SEND = 1'b0;
   localparam logic ACT_ACK  = 1'b1;

   // One input item.
   typedef struct packed {
      logic        action;
      logic [15:0] packet_tag;
      logic [31:0] preset_sequence;
      logic        is_ack_packet;
      logic [31:0] ack_number;
      logic [31:0] ack_bitmap;
   } req_type;

   // One result item.
   typedef struct packed {
      logic [31:0] assigned_sequence;
      logic        tracked;
      logic        table_full;
      logic        queued;
      logic [5:0]  cleared_count;
      logic [5:0]  outstanding_count;
   } rsp_type;

   // One table entry as it is kept in memory.
   typedef struct packed {
      logic        valid;
      logic [31:0] sequence_no;
      logic [15:0] tag;
   } entry_type;

   // Clamp a count to what the 6-bit result fields can hold.
   function automatic logic [5:0] sat_count(input logic [31:0] n);
      logic [5:0] r;
      if (n > 32'(COUNT_MAX)) begin
         r = COUNT_MAX;
      end else begin
         r = n[5:0];
      end
      return r;
   endfunction

endpackage

[rtl/reliable_udp_unacked_tracker.sv]
// ----------------------------------------------------------------------------
// reliable_udp_unacked_tracker
// Tracks unacknowledged reliable packets of one session in a table memory.
// Flow: a send that needs no table entry, or is dropped, gives its result
// in the cycle after start; a send that is given a sequence number goes
// through the table scan and then the write-back, an ack through the scan.
// Throughput: one item at a time; busy falls as the result is strobed.
// Reset: a clearing pass writes every entry invalid, with busy high. Results
// are strobed for one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
module reliable_udp_unacked_tracker #(
   parameter int TABLE_DEPTH = rut_pkg::TABLE_DEPTH_DEF
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   input  rut_pkg::req_type req_item,
   output logic            rsp_valid,
   output rut_pkg::rsp_type rsp_item,
   input  logic            csr_valid,
   output logic            csr_ready,
   input  logic            csr_data
);

   import rut_pkg::*;

   localparam int AW      = $clog2(TABLE_DEPTH);
   localparam int CW      = $clog2(TABLE_DEPTH + 1);
   localparam int ENTRY_W = $bits(entry_type);

   localparam logic [AW:0]   DEPTH_N  = TABLE_DEPTH[AW:0];
   localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_DEPTH - 1);

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_SCAN  = 2'd2;
   localparam logic [1:0] ST_WRITE = 2'd3;

   logic [1:0]    state_ff, state_in;
   logic [AW:0]   iss_ff, iss_in;
   logic          rd_vld_ff, rd_vld_in;
   logic [AW-1:0] rd_idx_ff, rd_idx_in;
   logic          hit_found_ff, hit_found_in;
   logic [AW-1:0] hit_idx_ff, hit_idx_in;
   logic          free_found_ff, free_found_in;
   logic [AW-1:0] free_idx_ff, free_idx_in;
   logic [CW-1:0] clr_cnt_ff, clr_cnt_in;
   logic [CW-1:0] count_ff, count_in;
   logic [31:0]   next_seq_ff, next_seq_in;
   logic [31:0]   assigned_ff, assigned_in;
   logic          open_ff, open_in;
   req_type       req_ff, req_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_item_ff, rsp_item_in;

   logic               ram_wr_en;
   logic [AW-1:0]      ram_wr_addr;
   logic [ENTRY_W-1:0] ram_wr_data;
   logic               ram_rd_en;
   logic [ENTRY_W-1:0] ram_rd_data;

   entry_type     rd_entry;
   entry_type     wr_entry;
   logic [31:0]   ser_diff;
   logic          acked;
   logic [CW-1:0] clr_sum;
   logic          slot_ok;
   logic [CW-1:0] count_dec;

   // Entry table.
   rut_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(TABLE_DEPTH)
   ) u_table (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_en  (ram_rd_en),
      .rd_addr(iss_ff[AW-1:0]),
      .rd_data(ram_rd_data)
   );

   // Per-entry decode of the word read back in the scan.
   assign rd_entry  = entry_type'(ram_rd_data);
   assign ser_diff  = req_ff.ack_number - rd_entry.sequence_no;
   assign acked     = rd_entry.valid && (ser_diff < SERIAL_HALF);
   assign clr_sum   = clr_cnt_ff + CW'(acked);
   assign count_dec = count_ff - clr_sum;
   assign slot_ok   = hit_found_ff || free_found_ff;

   // Control sequencer: clearing pass, idle, table scan and write-back.
   always_comb begin
      state_in      = state_ff;
      iss_in        = iss_ff;
      rd_vld_in     = 1'b0;
      rd_idx_in     = iss_ff[AW-1:0];
      hit_found_in  = hit_found_ff;
      hit_idx_in    = hit_idx_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      clr_cnt_in    = clr_cnt_ff;
      count_in      = count_ff;
      next_seq_in   = next_seq_ff;
      assigned_in   = assigned_ff;
      req_in        = req_ff;
      rsp_valid_in  = 1'b0;
      rsp_item_in   = rsp_item_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = rd_idx_ff;
      ram_rd_en     = 1'b0;
      wr_entry      = rd_entry;
      wr_entry.valid = 1'b0;

      open_in = open_ff;
      if (csr_valid && csr_ready) begin
         open_in = csr_data;
      end

      case (state_ff)
         ST_CLEAR: begin
            // Write every entry invalid, one per cycle.
            ram_wr_en   = 1'b1;
            ram_wr_addr = iss_ff[AW-1:0];
            wr_entry    = '0;
            if (iss_ff[AW-1:0] == LAST_IDX) begin
               iss_in   = '0;
               state_in = ST_IDLE;
            end else begin
               iss_in = iss_ff + 1'b1;
            end
         end

         ST_IDLE: begin
            if (start) begin
               req_in        = req_item;
               iss_in        = '0;
               hit_found_in  = 1'b0;
               free_found_in = 1'b0;
               hit_idx_in    = '0;
               free_idx_in   = '0;
               clr_cnt_in    = '0;
               rsp_item_in   = '0;
               rsp_item_in.outstanding_count = sat_count(32'(count_ff));
               if (req_item.action == ACT_ACK) begin
                  state_in = ST_SCAN;
               end else if (!open_ff) begin
                  // Dropped send: all zero but the count.
                  rsp_valid_in = 1'b1;
               end else if ((req_item.preset_sequence != 32'd0) ||
                            req_item.is_ack_packet) begin
                  // Sent as is, nothing recorded.
                  rsp_item_in.queued = 1'b1;
                  rsp_valid_in       = 1'b1;
               end else begin
                  assigned_in = next_seq_ff;
                  next_seq_in = next_seq_ff + 32'd1;
                  state_in    = ST_SCAN;
               end
            end
         end

         ST_SCAN: begin
            // Issue the next read while the previous entry comes back.
            if (iss_ff != DEPTH_N) begin
               ram_rd_en = 1'b1;
               iss_in    = iss_ff + 1'b1;
               rd_vld_in = 1'b1;
            end
            if (rd_vld_ff) begin
               if (req_ff.action == ACT_ACK) begin
                  // Drop every entry at or before the ack number.
                  if (acked) begin
                     ram_wr_en = 1'b1;
                  end
                  clr_cnt_in = clr_sum;
               end else begin
                  // First entry with the same sequence, else first free one.
                  if (rd_entry.valid && (rd_entry.sequence_no == assigned_ff) &&
                      !hit_found_ff) begin
                     hit_found_in = 1'b1;
                     hit_idx_in   = rd_idx_ff;
                  end
                  if (!rd_entry.valid && !free_found_ff) begin
                     free_found_in = 1'b1;
                     free_idx_in   = rd_idx_ff;
                  end
               end
               if (rd_idx_ff == LAST_IDX) begin
                  if (req_ff.action == ACT_ACK) begin
                     count_in     = count_dec;
                     rsp_item_in  = '0;
                     rsp_item_in.cleared_count     = sat_count(32'(clr_sum));
                     rsp_item_in.outstanding_count = sat_count(32'(count_dec));
                     rsp_valid_in = 1'b1;
                     state_in     = ST_IDLE;
                  end else begin
                     state_in = ST_WRITE;
                  end
               end
            end
         end

         ST_WRITE: begin
            // Record the sent packet in the chosen entry.
            ram_wr_addr    = hit_found_ff ? hit_idx_ff : free_idx_ff;
            ram_wr_en      = slot_ok;
            wr_entry.valid       = 1'b1;
            wr_entry.sequence_no = assigned_ff;
            wr_entry.tag         = req_ff.packet_tag;
            count_in = count_ff + CW'(free_found_ff && !hit_found_ff);
            rsp_item_in = '0;
            rsp_item_in.assigned_sequence = assigned_ff;
            rsp_item_in.tracked           = slot_ok;
            rsp_item_in.table_full        = !slot_ok;
            rsp_item_in.queued            = 1'b1;
            rsp_item_in.outstanding_count = sat_count(32'(count_in));
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      ram_wr_data = ENTRY_W'(wr_entry);
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         iss_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         count_ff     <= '0;
         next_seq_ff  <= 32'd1;
         open_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         iss_ff       <= iss_in;
         rd_vld_ff    <= rd_vld_in;
         count_ff     <= count_in;
         next_seq_ff  <= next_seq_in;
         open_ff      <= open_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      rd_idx_ff     <= rd_idx_in;
      hit_found_ff  <= hit_found_in;
      hit_idx_ff    <= hit_idx_in;
      free_found_ff <= free_found_in;
      free_idx_ff   <= free_idx_in;
      clr_cnt_ff    <= clr_cnt_in;
      assigned_ff   <= assigned_in;
      req_ff        <= req_in;
      rsp_item_ff   <= rsp_item_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;
   assign csr_ready = 1'b1;

   // The outstanding counter never exceeds the table size.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(TABLE_DEPTH))
      else $error("outstanding count exceeds table depth");

   // The clearing pass never produces a result.
   a_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |=> !rsp_valid_ff)
      else $error("result during clearing pass");

   // A result reports the count that the counter now holds.
   a_count_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_item_ff.outstanding_count == sat_count(32'(count_ff))))
      else $error("reported count differs from counter");

   // The write state always follows a completed scan.
   a_write_after_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WRITE) |-> ($past(state_ff) == ST_SCAN && !rd_vld_ff))
      else $error("write-back without a finished scan");

endmodule

[rtl/rut_ram.sv]
// ----------------------------------------------------------------------------
// rut_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module rut_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port, registered.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[verif/reliable_udp_unacked_tracker_tb.sv]
// ----------------------------------------------------------------------------
// reliable_udp_unacked_tracker_tb
// Self-checking testbench for the unacknowledged packet tracker. A scoreboard
// class keeps its own copy of the session flag, the sequence counter and the
// entry table. It predicts every result from the accepted items and compares
// each strobed result with the oldest prediction, field by field. Directed
// items cover the edge cases. Several random phases follow, with the session
// open or closed, send-heavy or even mixes, and random start gaps.
// ----------------------------------------------------------------------------
module reliable_udp_unacked_tracker_tb;

   timeunit 1ns;
   timeprecision 1ps;

   import rut_pkg::*;

   localparam int DEPTH           = TABLE_DEPTH_DEF;
   localparam int PHASE_COUNT     = 6;
   localparam int ITEMS_PER_PHASE = 155;
   localparam int RUN_LIMIT_NS    = 5_000_000;

   // Predicts the tracker's results and checks the ones that come back.
   class unacked_table_model;
      bit          session_open;
      logic [31:0] next_seq;
      bit          entry_valid[DEPTH];
      logic [31:0] entry_seq[DEPTH];
      logic [15:0] entry_tag[DEPTH];
      rsp_type     pending_results[$];
      int          error_count;
      int          send_count;
      int          ack_count;
      int          tracked_count;
      int          full_count;
      int          cleared_total;

      function new();
         session_open = 1'b0;
         next_seq     = 32'd1;
         foreach (entry_valid[k]) begin
            entry_valid[k] = 1'b0;
            entry_seq[k]   = '0;
            entry_tag[k]   = '0;
         end
         error_count   = 0;
         send_count    = 0;
         ack_count     = 0;
         tracked_count = 0;
         full_count    = 0;
         cleared_total = 0;
      endfunction

      function logic [5:0] clamp_count(int n);
         return (n > int'(COUNT_MAX)) ? COUNT_MAX : 6'(n);
      endfunction

      // Works out the result of one accepted item and updates the table.
      function void note_request(req_type r);
         rsp_type     e;
         int          slot;
         int          cleared;
         int          live;
         logic [31:0] ser_dist;
         e       = '0;
         slot    = -1;
         cleared = 0;
         live    = 0;
         if (r.action == ACT_SEND) begin
            send_count++;
            if (session_open) begin
               e.queued = 1'b1;
               if (r.preset_sequence == 32'd0 && !r.is_ack_packet) begin
                  e.assigned_sequence = next_seq;
                  next_seq = next_seq + 32'd1;
                  // A live entry with the same number is reused first.
                  for (int k = 0; k < DEPTH; k++) begin
                     if (slot < 0 && entry_valid[k] &&
                         entry_seq[k] == e.assigned_sequence) begin
                        slot = k;
                     end
                  end
                  for (int k = 0; k < DEPTH; k++) begin
                     if (slot < 0 && !entry_valid[k]) begin
                        slot = k;
                     end
                  end
                  if (slot >= 0) begin
                     entry_valid[slot] = 1'b1;
                     entry_seq[slot]   = e.assigned_sequence;
                     entry_tag[slot]   = r.packet_tag;
                     e.tracked         = 1'b1;
                  end else begin
                     e.table_full = 1'b1;
                  end
               end
            end
         end else begin
            ack_count++;
            // Clear every entry at or before the ack number in serial order.
            for (int k = 0; k < DEPTH; k++) begin
               ser_dist = r.ack_number - entry_seq[k];
               if (entry_valid[k] && ser_dist < SERIAL_HALF) begin
                  entry_valid[k] = 1'b0;
                  cleared++;
               end
            end
         end
         foreach (entry_valid[k]) begin
            if (entry_valid[k]) begin
               live++;
            end
         end
         e.cleared_count     = clamp_count(cleared);
         e.outstanding_count = clamp_count(live);
         pending_results.push_back(e);
      endfunction

      function void compare_field(string field, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, field, want, got);
            error_count++;
         end
      endfunction

      // Compares one strobed result with the oldest prediction.
      function void check_result(rsp_type got);
         rsp_type e;
         if (pending_results.size() == 0) begin
            $display("%0t: result with nothing expected, actual %p", $time, got);
            error_count++;
            return;
         end
         e = pending_results.pop_front();
         compare_field("assigned_sequence", e.assigned_sequence, got.assigned_sequence);
         compare_field("tracked", 32'(e.tracked), 32'(got.tracked));
         compare_field("table_full", 32'(e.table_full), 32'(got.table_full));
         compare_field("queued", 32'(e.queued), 32'(got.queued));
         compare_field("cleared_count", 32'(e.cleared_count), 32'(got.cleared_count));
         compare_field("outstanding_count", 32'(e.outstanding_count),
                       32'(got.outstanding_count));
         tracked_count += e.tracked;
         full_count    += e.table_full;
         cleared_total += e.cleared_count;
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_item;
   logic    rsp_valid;
   rsp_type rsp_item;
   logic    csr_valid;
   logic    csr_ready;
   logic    csr_data;

   unacked_table_model tracker_model = new();

   reliable_udp_unacked_tracker #(
      .TABLE_DEPTH(DEPTH)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Results are strobed for one cycle and checked at the closing edge.
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1) begin
         tracker_model.check_result(rsp_item);
      end
   end

   // Hard stop in case the block hangs.
   initial begin
      #(RUN_LIMIT_NS * 1ns);
      $display("Simulation FAILED");
      $finish;
   end

   function automatic req_type make_send(logic [15:0] tag, logic [31:0] preset,
                                         logic is_ack);
      req_type r;
      r.action          = ACT_SEND;
      r.packet_tag      = tag;
      r.preset_sequence = preset;
      r.is_ack_packet   = is_ack;
      r.ack_number      = $urandom;
      r.ack_bitmap      = $urandom;
      return r;
   endfunction

   function automatic req_type make_ack(logic [31:0] number, logic [31:0] bitmap);
      req_type r;
      r.action          = ACT_ACK;
      r.packet_tag      = 16'($urandom);
      r.preset_sequence = $urandom;
      r.is_ack_packet   = 1'($urandom_range(0, 1));
      r.ack_number      = number;
      r.ack_bitmap      = bitmap;
      return r;
   endfunction

   // Ack numbers mostly land just behind the newest sequence handed out.
   function automatic logic [31:0] pick_ack_number();
      int          k;
      logic [31:0] newest;
      k      = $urandom_range(0, 99);
      newest = tracker_model.next_seq - 32'd1;
      if (k < 60) begin
         return newest - 32'($urandom_range(0, 40));
      end else if (k < 75) begin
         return $urandom;
      end else if (k < 88) begin
         return newest - 32'($urandom_range(100, 2000));
      end
      return newest + 32'($urandom_range(0, 8));
   endfunction

   // Mostly plain sends that get tracked, with some presets and ack packets.
   function automatic req_type pick_item(int send_pct);
      int k;
      if ($urandom_range(0, 99) >= send_pct) begin
         return make_ack(pick_ack_number(), $urandom);
      end
      k = $urandom_range(0, 99);
      if (k < 75) begin
         return make_send(16'($urandom), 32'd0, 1'b0);
      end else if (k < 85) begin
         return make_send(16'($urandom), $urandom, 1'b0);
      end else if (k < 95) begin
         return make_send(16'($urandom), ($urandom_range(0, 1) != 0) ? 32'd0 : $urandom,
                          1'b1);
      end
      return make_send(16'($urandom), $urandom, 1'($urandom_range(0, 1)));
   endfunction

   // Roughly a third of the items wait first; some gaps reach into a scan.
   function automatic int pick_gap(bit no_idle);
      if (no_idle || $urandom_range(0, 99) >= 32) begin
         return 0;
      end
      if ($urandom_range(0, 3) == 0) begin
         return $urandom_range(DEPTH / 2, DEPTH + 6);
      end
      return $urandom_range(1, 4);
   endfunction

   // Presents one item and holds it until the block takes it.
   task automatic issue_item(input req_type r, input int gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_item <= r;
      start    <= 1'b1;
      do @(posedge clock); while (busy);
      tracker_model.note_request(r);
   endtask

   // Stops sending until every predicted result has come back.
   task automatic drain_results();
      start <= 1'b0;
      while (tracker_model.pending_results.size() != 0 || busy) begin
         @(posedge clock);
      end
   endtask

   task automatic write_session(input bit open_flag);
      drain_results();
      csr_valid <= 1'b1;
      csr_data  <= open_flag;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      tracker_model.session_open = open_flag;
   endtask

   // Main stimulus.
   initial begin
      int          send_pct[PHASE_COUNT];
      bit          open_in_phase[PHASE_COUNT];
      logic [31:0] first_seq;
      int          total_items;

      send_pct      = '{90, 65, 55, 50, 80, 60};
      open_in_phase = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};
      reset     = 1'b1;
      start     = 1'b0;
      req_item  = '0;
      csr_valid = 1'b0;
      csr_data  = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      // Let the clearing pass after reset finish.
      do @(posedge clock); while (busy);

      // Closed session: the send is dropped, the ack is still processed.
      issue_item(make_send(16'h1234, 32'd0, 1'b0), 0);
      issue_item(make_ack(32'd0, 32'hFFFF_FFFF), 1);
      write_session(1'b1);

      // Tag extremes, preset sequences and ack packets.
      first_seq = tracker_model.next_seq;
      issue_item(make_send(16'h0000, 32'd0, 1'b0), 0);
      issue_item(make_send(16'hFFFF, 32'd0, 1'b0), 0);
      issue_item(make_send(16'h5A5A, 32'hFFFF_FFFF, 1'b0), 0);
      issue_item(make_send(16'hA5A5, 32'd0, 1'b1), 0);
      issue_item(make_send(16'h0001, 32'd1, 1'b1), 2);
      issue_item(make_send(16'h8000, 32'h8000_0000, 1'b0), 0);
      issue_item(make_send(16'h7FFF, 32'd0, 1'b0), 0);

      // Serial order boundaries around the oldest entry.
      issue_item(make_ack(first_seq - 32'd1, 32'hFFFF_FFFF), 0);
      issue_item(make_ack(first_seq + SERIAL_HALF, 32'h0000_0000), 0);
      issue_item(make_ack(first_seq + SERIAL_HALF - 32'd1, 32'h0000_0001), 3);
      issue_item(make_ack(32'hFFFF_FFFF, 32'hFFFF_FFFF), 0);
      issue_item(make_send(16'hC3C3, 32'd0, 1'b0), 0);
      issue_item(make_send(16'h3C3C, 32'd0, 1'b0), 0);
      issue_item(make_ack(tracker_model.next_seq + 32'd5, 32'h8000_0000), 0);
      issue_item(make_ack(32'h0000_0000, 32'h0000_0000), 0);
      issue_item(make_ack(32'h7FFF_FFFF, 32'h5555_5555), 0);
      total_items = 18;

      // Random phases, one session setting each.
      for (int p = 0; p < PHASE_COUNT; p++) begin
         write_session(open_in_phase[p]);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            // One mid-phase pause until the block has caught up.
            if (p == 1 && n == ITEMS_PER_PHASE / 2) begin
               drain_results();
            end
            issue_item(pick_item(send_pct[p]), pick_gap(p == 2));
            total_items++;
         end
      end

      drain_results();
      repeat (DEPTH + 8) @(posedge clock);
      if (tracker_model.pending_results.size() != 0) begin
         $display("%0t: %0d expected results never arrived", $time,
                  tracker_model.pending_results.size());
         tracker_model.error_count++;
      end

      $display("Ran %0d items: %0d sends and %0d acks over %0d session settings.",
               total_items, tracker_model.send_count, tracker_model.ack_count,
               PHASE_COUNT + 1);
      $display("%0d sends were tracked, %0d met a full table, %0d entries were acked.",
               tracker_model.tracked_count, tracker_model.full_count,
               tracker_model.cleared_total);
      if (tracker_model.error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

[sim.f]
rtl/rut_pkg.sv
rtl/rut_ram.sv
rtl/reliable_udp_unacked_tracker.sv
verif/reliable_udp_unacked_tracker_tb.sv
